// ===== src/rtt_estimator_timeout_defines.svh =====
// Assertion macros used by the RTT estimator top level.
`ifndef RTT_ESTIMATOR_TIMEOUT_DEFINES_SVH
`define RTT_ESTIMATOR_TIMEOUT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("RTT estimator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("RTT estimator check failed");

`endif

// ===== src/rtte_pkg.sv =====
// Types, constants and microcode program of the RTT estimator.
package rtte_pkg;

    localparam int RTT_W  = 24;
    localparam int TMO_W  = 27;
    localparam int GAIN_W = 9;
    localparam int ACC_W  = 32;
    localparam int PC_W   = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE      = 9'd256;
    localparam logic [GAIN_W-1:0] AVG_GAIN_RST  = 9'd224;
    localparam logic [GAIN_W-1:0] DEV_GAIN_RST  = 9'd192;
    localparam logic [PC_W-1:0]   STEP_WAIT     = 3'd0;
    localparam logic [PC_W-1:0]   STEP_LAST     = 3'd4;

    typedef enum logic
    {
        REG_AVG_GAIN = 1'b0,
        REG_DEV_GAIN = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        GAIN_AVG = 1'b0,
        GAIN_DEV = 1'b1
    } gain_sel_t;

    typedef enum logic [1:0]
    {
        OPND_AVG = 2'd0,
        OPND_RTT = 2'd1,
        OPND_DEV = 2'd2,
        OPND_ERR = 2'd3
    } opnd_sel_t;

    typedef enum logic [1:0]
    {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef struct packed
    {
        logic      wait_in;
        logic      hold_out;
        logic      last;
        gain_sel_t gain_sel;
        logic      gain_inv;
        opnd_sel_t opnd_sel;
        acc_op_t   acc_op;
        logic      wr_avg;
        logic      wr_dev;
    } ucode_t;

    // Program: steps 0 to 3 each multiply one gain factor by one operand; step 4 writes the deviation.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t cw;
        begin
            cw = '{wait_in: 1'b0, hold_out: 1'b0, last: 1'b1, gain_sel: GAIN_AVG,
                   gain_inv: 1'b0, opnd_sel: OPND_AVG, acc_op: ACC_HOLD,
                   wr_avg: 1'b0, wr_dev: 1'b0};
            unique case (pc)
                3'd0:
                begin
                    cw.wait_in  = 1'b1;
                    cw.last     = 1'b0;
                    cw.gain_sel = GAIN_AVG;
                    cw.gain_inv = 1'b1;
                    cw.opnd_sel = OPND_AVG;
                    cw.acc_op   = ACC_LOAD;
                end
                3'd1:
                begin
                    cw.last     = 1'b0;
                    cw.gain_sel = GAIN_AVG;
                    cw.opnd_sel = OPND_RTT;
                    cw.acc_op   = ACC_ADD;
                end
                3'd2:
                begin
                    cw.last     = 1'b0;
                    cw.gain_sel = GAIN_DEV;
                    cw.gain_inv = 1'b1;
                    cw.opnd_sel = OPND_DEV;
                    cw.acc_op   = ACC_LOAD;
                    cw.wr_avg   = 1'b1;
                end
                3'd3:
                begin
                    cw.last     = 1'b0;
                    cw.gain_sel = GAIN_DEV;
                    cw.opnd_sel = OPND_ERR;
                    cw.acc_op   = ACC_ADD;
                end
                3'd4:
                begin
                    cw.hold_out = 1'b1;
                    cw.wr_dev   = 1'b1;
                end
                default:
                begin
                    cw.last = 1'b1;
                end
            endcase
            return cw;
        end
    endfunction

endpackage

// ===== src/rtt_estimator_timeout.sv =====
// Top level of the RTT estimator with retransmit timeout.
// Each request carries one round-trip time sample in unsigned Q16.8 ms and yields
// the new smoothed average, the new smoothed deviation and the timeout, which is
// the average plus four times the deviation. One shared 9 by 24 bit
// multiply-accumulate unit works through a five-step microcode program: two
// products for the average and two for the deviation. A sample is accepted only
// at the first step, so a new sample is not accepted until the program has run
// its last step for the previous one and returned to its first step. A result
// waits in an output register; the next sample can be accepted meanwhile, and
// the program holds at its last step only while that register is still full and
// m_tready is low. Gain registers above one are treated as one.
`include "rtt_estimator_timeout_defines.svh"

module rtt_estimator_timeout
    import rtte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // rtt_sample[23:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,   // avg_rtt_out[23:0], deviation_out[47:24],
                                         // timeout_out[74:48], zero[79:75]
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [GAIN_W-1:0] cfg_data
);

    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [GAIN_W-1:0] avg_gain_reg;
    logic [GAIN_W-1:0] dev_gain_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_busy;
    logic              go;
    ucode_t            cw;
    logic [RTT_W-1:0]  res_avg;
    logic [RTT_W-1:0]  res_dev;
    logic [TMO_W-1:0]  res_tmo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_gain_reg <= AVG_GAIN_RST;
            dev_gain_reg <= DEV_GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_AVG_GAIN: avg_gain_reg <= cfg_data;
                REG_DEV_GAIN: dev_gain_reg <= cfg_data;
                default:      avg_gain_reg <= avg_gain_reg;
            endcase
        end
    end

    always_comb
    begin
        cw       = ucode_rom(pc_reg);
        out_busy = out_valid_reg && !m_tready;
        go       = !(cw.wait_in && !s_tvalid) && !(cw.hold_out && out_busy);
        if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (cw.last)
        begin
            pc_next = STEP_WAIT;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end
        if (go && cw.wr_dev)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    rtte_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cw       (cw),
        .go       (go),
        .rtt_in   (s_tdata),
        .avg_gain (avg_gain_reg),
        .dev_gain (dev_gain_reg),
        .res_avg  (res_avg),
        .res_dev  (res_dev),
        .res_tmo  (res_tmo)
    );

    assign s_tready = cw.wait_in;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, res_tmo, res_dev, res_avg};

    `RTTE_ASSERT_IMPL(a_tmo_sum, clk, rst_n, m_tvalid,
        {3'b000, m_tdata[23:0]} + {1'b0, m_tdata[47:24], 2'b00} == m_tdata[74:48])
    `RTTE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready,
        !s_tready && pc_reg == 3'd1)
    `RTTE_ASSERT_IMPL(a_result_from_last, clk, rst_n, $rose(out_valid_reg),
        $past(pc_reg) == STEP_LAST)

endmodule

// ===== src/rtte_datapath.sv =====
// Multiply-accumulate datapath, state and result registers of the RTT estimator.
module rtte_datapath
    import rtte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ucode_t            cw,
    input  logic              go,
    input  logic [RTT_W-1:0]  rtt_in,
    input  logic [GAIN_W-1:0] avg_gain,
    input  logic [GAIN_W-1:0] dev_gain,
    output logic [RTT_W-1:0]  res_avg,
    output logic [RTT_W-1:0]  res_dev,
    output logic [TMO_W-1:0]  res_tmo
);

    logic [RTT_W-1:0]  avg_reg;
    logic [RTT_W-1:0]  dev_reg;
    logic [RTT_W-1:0]  rtt_reg;
    logic [RTT_W-1:0]  err_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [RTT_W-1:0]  res_avg_reg;
    logic [RTT_W-1:0]  res_dev_reg;
    logic [TMO_W-1:0]  res_tmo_reg;

    logic [GAIN_W-1:0]       gain_clamped;
    logic [GAIN_W-1:0]       factor;
    logic [RTT_W-1:0]        operand;
    logic [RTT_W+GAIN_W-1:0] product;
    logic [RTT_W-1:0]        acc_hi;
    logic [RTT_W-1:0]        err_next;

    always_comb
    begin
        gain_clamped = (cw.gain_sel == GAIN_DEV) ? dev_gain : avg_gain;
        if (gain_clamped > GAIN_ONE)
        begin
            gain_clamped = GAIN_ONE;
        end
        factor = cw.gain_inv ? (GAIN_ONE - gain_clamped) : gain_clamped;
        unique case (cw.opnd_sel)
            OPND_AVG: operand = avg_reg;
            OPND_RTT: operand = rtt_reg;
            OPND_DEV: operand = dev_reg;
            OPND_ERR: operand = err_reg;
            default:  operand = avg_reg;
        endcase
        product = factor * operand;
        unique case (cw.acc_op)
            ACC_LOAD: acc_next = product[ACC_W-1:0];
            ACC_ADD:  acc_next = acc_reg + product[ACC_W-1:0];
            default:  acc_next = acc_reg;
        endcase
        acc_hi   = acc_reg[ACC_W-1:8];
        err_next = (rtt_reg >= acc_hi) ? (rtt_reg - acc_hi) : (acc_hi - rtt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
            dev_reg <= '0;
        end
        else if (go)
        begin
            if (cw.wr_avg)
            begin
                avg_reg <= acc_hi;
            end
            if (cw.wr_dev)
            begin
                dev_reg <= acc_hi;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= acc_next;
            if (cw.wait_in)
            begin
                rtt_reg <= rtt_in;
            end
            if (cw.wr_avg)
            begin
                err_reg <= err_next;
            end
            if (cw.wr_dev)
            begin
                res_avg_reg <= avg_reg;
                res_dev_reg <= acc_hi;
                res_tmo_reg <= {3'b000, avg_reg} + {1'b0, acc_hi, 2'b00};
            end
        end
    end

    assign res_avg = res_avg_reg;
    assign res_dev = res_dev_reg;
    assign res_tmo = res_tmo_reg;

endmodule
